### sv/bcq_pkg.sv
// Shared types, constants and helper functions for the byte circular queue.
package bcq_pkg;

   localparam int MAX_DEPTH = 16;
   localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   // Wide enough to hold the slot count itself.
   localparam int SLOT_W    = IDX_W + 1;
   localparam int CAP_W     = 5;
   localparam int DATA_W    = 8;
   localparam int CAP_RESET = 16;
   localparam int CAP_RESET_SAT = (CAP_RESET > MAX_DEPTH) ? MAX_DEPTH :
                                  ((CAP_RESET < 1) ? 1 : CAP_RESET);

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_DELETE  = 2'd1,
      OP_DISPLAY = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef struct packed {
      opcode_type          opcode;
      logic [DATA_W-1:0]   value;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]   data;
      status_type          status;
      logic                last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic ins_ok;
      logic ins_ovf;
      logic del_start;
      logic del_udf;
      logic disp_start;
      logic disp_empty;
      logic del_emit;
      logic disp_emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic empty;
      logic walk_at_tail;
   } stat_type;

   function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx,
                                                   input logic [SLOT_W-1:0] slots);
      logic [SLOT_W-1:0] n;
      n = SLOT_W'(idx) + SLOT_W'(1);
      return (n >= slots) ? '0 : n[IDX_W-1:0];
   endfunction

   function automatic logic [SLOT_W-1:0] saturate_cap(input logic [CAP_W-1:0] raw);
      logic [SLOT_W-1:0] res;
      if (raw == '0) begin
         res = SLOT_W'(1);
      end else if (int'(raw) > MAX_DEPTH) begin
         res = SLOT_W'(MAX_DEPTH);
      end else begin
         res = SLOT_W'(raw);
      end
      return res;
   endfunction

endpackage

### sv/bcq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bcq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/bcq_ctrl.sv
// Controller state machine for the byte circular queue.
module bcq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  bcq_pkg::opcode_type opcode,
   input  bcq_pkg::stat_type   stat,
   output bcq_pkg::cmd_type    cmd,
   output logic                busy
);
   import bcq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DEL,
      S_DISP
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (opcode)
                  OP_INSERT: begin
                     cmd.ins_ovf = stat.full;
                     cmd.ins_ok  = !stat.full;
                  end
                  OP_DELETE: begin
                     if (stat.empty) begin
                        cmd.del_udf = 1'b1;
                     end else begin
                        cmd.del_start = 1'b1;
                        state_in      = S_DEL;
                     end
                  end
                  OP_DISPLAY: begin
                     if (stat.empty) begin
                        cmd.disp_empty = 1'b1;
                     end else begin
                        cmd.disp_start = 1'b1;
                        state_in       = S_DISP;
                     end
                  end
                  default: begin
                     // The unused code is dropped without a result.
                  end
               endcase
            end
         end
         S_DEL: begin
            cmd.del_emit = 1'b1;
            state_in     = S_IDLE;
         end
         S_DISP: begin
            cmd.disp_emit = 1'b1;
            if (stat.walk_at_tail) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/bcq_datapath.sv
// Datapath of the byte circular queue: pointers, slot store and result register.
module bcq_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  bcq_pkg::cmd_type          cmd,
   input  bcq_pkg::req_type          req_payload,
   input  logic                      csr_we,
   input  logic [bcq_pkg::CAP_W-1:0] csr_wdata,
   output bcq_pkg::stat_type         stat,
   output logic                      rsp_valid,
   output bcq_pkg::rsp_type          rsp_payload
);
   import bcq_pkg::*;

   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [IDX_W-1:0]  walk_ff, walk_in;
   logic              empty_ff, empty_in;
   logic [SLOT_W-1:0] cap_ff, cap_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [IDX_W-1:0]  tail_next;
   logic [IDX_W-1:0]  walk_next;
   logic [IDX_W-1:0]  raddr;
   logic [IDX_W-1:0]  waddr;
   logic [DATA_W-1:0] rdata;

   assign tail_next = next_index(tail_ff, cap_ff);
   assign walk_next = next_index(walk_ff, cap_ff);

   assign stat.empty        = empty_ff;
   assign stat.full         = !empty_ff && (tail_next == head_ff);
   assign stat.walk_at_tail = (walk_ff == tail_ff);

   // While walking, fetch the entry after the one being shown.
   assign raddr = cmd.disp_emit ? walk_next : head_ff;
   assign waddr = empty_ff ? '0 : tail_next;

   bcq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_DEPTH)
   ) u_slot_store (
      .clock (clock),
      .we    (cmd.ins_ok),
      .waddr (waddr),
      .wdata (req_payload.value),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      walk_in      = walk_ff;
      empty_in     = empty_ff;
      cap_in       = cap_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '{data: '0, status: ST_OK, last: 1'b1};

      priority if (csr_we) begin
         // A capacity write also flushes the queue.
         cap_in   = saturate_cap(csr_wdata);
         head_in  = '0;
         tail_in  = '0;
         empty_in = 1'b1;
      end else if (cmd.ins_ok) begin
         if (empty_ff) begin
            head_in  = '0;
            tail_in  = '0;
            empty_in = 1'b0;
         end else begin
            tail_in = tail_next;
         end
         rsp_valid_in = 1'b1;
      end else if (cmd.ins_ovf) begin
         rsp_valid_in  = 1'b1;
         rsp_in.status = ST_OVERFLOW;
      end else if (cmd.del_udf) begin
         rsp_valid_in  = 1'b1;
         rsp_in.status = ST_UNDERFLOW;
      end else if (cmd.disp_empty) begin
         rsp_valid_in  = 1'b1;
         rsp_in.status = ST_EMPTY;
      end else if (cmd.del_start) begin
         // The head is read in this cycle, so the pointers may move now.
         if (head_ff == tail_ff) begin
            head_in  = '0;
            tail_in  = '0;
            empty_in = 1'b1;
         end else begin
            head_in = next_index(head_ff, cap_ff);
         end
      end else if (cmd.disp_start) begin
         walk_in = head_ff;
      end else if (cmd.del_emit) begin
         rsp_valid_in = 1'b1;
         rsp_in.data  = rdata;
      end else if (cmd.disp_emit) begin
         rsp_valid_in = 1'b1;
         rsp_in.data  = rdata;
         rsp_in.last  = stat.walk_at_tail;
         walk_in      = walk_next;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         walk_ff      <= '0;
         empty_ff     <= 1'b1;
         cap_ff       <= SLOT_W'(CAP_RESET_SAT);
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         walk_ff      <= walk_in;
         empty_ff     <= empty_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### sv/byte_circular_queue_core.sv
// Top level of the byte circular queue: controller and datapath joined together.
//
// A transaction is taken when start is high and busy is low. Every result
// appears on rsp_payload for one cycle with rsp_valid high and cannot be
// held off, so the receiver must take it in that cycle. Insert, overflow,
// underflow and display of an empty queue give their single result in the
// cycle after the transaction and keep busy low, so one such transaction can
// be taken every cycle. Delete passes through the S_DEL state, since the slot
// store is a RAM with a registered read port. Display of the held entries
// stays in S_DISP and gives one result per cycle, the walk being paced by
// that same read port. Writing the capacity register empties the queue.
module byte_circular_queue_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  bcq_pkg::req_type          req_payload,
   output logic                      rsp_valid,
   output bcq_pkg::rsp_type          rsp_payload,
   input  logic                      csr_we,
   input  logic [bcq_pkg::CAP_W-1:0] csr_wdata
);
   import bcq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   bcq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .opcode (req_payload.opcode),
      .stat   (stat),
      .cmd    (cmd),
      .busy   (busy)
   );

   bcq_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule
